// ===== design/nfa_pkg.sv =====
// Shared types, constants and helpers for the NFA epsilon matcher.
package nfa_pkg;

  localparam int NUM_STATES  = 16;
  localparam int SYMBOL_BITS = 8;

  localparam int STATE_W  = $clog2(NUM_STATES);
  localparam int ADDR_W   = STATE_W + SYMBOL_BITS;
  localparam int MASK_W   = 16;
  localparam int FROM_W   = 4;
  localparam int SYM_W    = 8;
  localparam int CMD_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FEED  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MASK = 1'b1;

  localparam logic [SYMBOL_BITS-1:0] EPSILON_SYM = '0;

  typedef logic [NUM_STATES-1:0]  set_t;
  typedef logic [STATE_W-1:0]     state_idx_t;
  typedef logic [SYMBOL_BITS-1:0] sym_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_WR_TAB,
    OP_WR_EPS,
    OP_BEGIN,
    OP_FEED
  } op_t;

  typedef struct packed {
    op_t        op;
    state_idx_t from;
    sym_t       sym;
    set_t       mask;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } q_wr_t;

  function automatic set_t mask_to_set(logic [MASK_W-1:0] m);
    set_t s;
    s = '0;
    for (int i = 0; i < NUM_STATES; i++) begin
      if (i < MASK_W) begin
        s[i] = m[i];
      end
    end
    return s;
  endfunction

  function automatic logic [MASK_W-1:0] set_to_mask(set_t s);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (i < NUM_STATES) begin
        m[i] = s[i];
      end
    end
    return m;
  endfunction

endpackage

// ===== design/nfa_if.sv =====
// Handshake interfaces for the item and result channels.
interface nfa_in_if import nfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [FROM_W-1:0] from_state;
  logic [SYM_W-1:0]  symbol;
  logic [MASK_W-1:0] next_mask;

  modport source(output valid, output command, output from_state, output symbol,
                 output next_mask, input ready);
  modport sink(input valid, input command, input from_state, input symbol,
               input next_mask, output ready);
endinterface

interface nfa_out_if import nfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] active_mask;
  logic              accepted;

  modport source(output valid, output active_mask, output accepted, input ready);
  modport sink(input valid, input active_mask, input accepted, output ready);
endinterface

// ===== design/nfa_epsilon_matcher.sv =====
// Top level: register bank and front/queue/back wiring of the NFA matcher.
//
//  port   dir  handshake     word contents
//  in_if  in   valid/ready   command, from_state, symbol, next_mask
//  out_if out  valid/ready   active_mask, accepted
//  cfg_*  in   cfg_we only   cfg_index selects start_state or accept_mask
//
// After reset the back end clears the 4096-entry transition memory, one entry
// a cycle; in_if.ready stays low until the clearing is done.
// Write and ignored words go straight to a result; begin loads the start state,
// and feed first reads the transition memory once per state; both then repeat
// epsilon passes until the active set stops growing.
// Up to two words queue ahead of the back end; a held result stalls the back end, and in_if once the queue is full.
module nfa_epsilon_matcher import nfa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  nfa_in_if.sink                in_if,
  nfa_out_if.source             out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [FROM_W-1:0] start_state_r;
  logic [MASK_W-1:0] accept_mask_r;
  q_wr_t             q_wr;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  item_t             q_head;
  logic              back_live;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_state_r <= '0;
      accept_mask_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_STATE: start_state_r <= cfg_wdata[FROM_W-1:0];
        CFG_ACCEPT_MASK: accept_mask_r <= cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  nfa_front u_front (
    .in_if     (in_if),
    .q_full    (q_full),
    .back_live (back_live),
    .q_wr      (q_wr)
  );

  nfa_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (q_head)
  );

  nfa_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .live        (back_live),
    .start_state (start_state_r),
    .accept_mask (accept_mask_r),
    .out_if      (out_if)
  );

endmodule

// ===== design/nfa_front.sv =====
// Front end: accepts input words and decodes them into queue operations.
module nfa_front import nfa_pkg::*; (
  nfa_in_if.sink in_if,
  input  logic   q_full,
  input  logic   back_live,
  output q_wr_t  q_wr
);

  sym_t sym;
  logic from_ok;

  assign sym     = in_if.symbol[SYMBOL_BITS-1:0];
  assign from_ok = int'(in_if.from_state) < NUM_STATES;

  assign in_if.ready = back_live && !q_full;

  always_comb begin
    q_wr.push      = in_if.valid && in_if.ready;
    q_wr.item.from = STATE_W'(in_if.from_state);
    q_wr.item.sym  = sym;
    q_wr.item.mask = mask_to_set(in_if.next_mask);
    case (in_if.command)
      CMD_WRITE: begin
        if (!from_ok) begin
          q_wr.item.op = OP_NOP;
        end else if (sym == EPSILON_SYM) begin
          q_wr.item.op = OP_WR_EPS;
        end else begin
          q_wr.item.op = OP_WR_TAB;
        end
      end
      CMD_BEGIN: q_wr.item.op = OP_BEGIN;
      CMD_FEED:  q_wr.item.op = (sym == EPSILON_SYM) ? OP_NOP : OP_FEED;
      default:   q_wr.item.op = OP_NOP;
    endcase
  end

endmodule

// ===== design/nfa_queue.sv =====
// Short FIFO of decoded operations between front and back ends.
module nfa_queue import nfa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  q_wr_t q_wr,
  input  logic  pop,
  output logic  full,
  output logic  empty,
  output item_t head
);

  item_t             buf_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = cnt_r == QCNT_W'(QUEUE_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = buf_r[rd_ptr_r];

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = q_wr.push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(q_wr.push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      buf_r[wr_ptr_r] <= q_wr.item;
    end
  end

endmodule

// ===== design/nfa_back.sv =====
// Back end: transition memory, epsilon moves, set update and result register.
module nfa_back import nfa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  item_t       q_head,
  output logic        q_pop,
  output logic        live,
  input  logic [FROM_W-1:0] start_state,
  input  logic [MASK_W-1:0] accept_mask,
  nfa_out_if.source   out_if
);

  typedef enum logic [5:0] {
    ST_CLEAR    = 6'b000001,
    ST_IDLE     = 6'b000010,
    ST_SCAN     = 6'b000100,
    ST_SCAN_END = 6'b001000,
    ST_CLOSE    = 6'b010000,
    ST_DONE     = 6'b100000
  } bstate_t;

  bstate_t           state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  set_t              active_r, active_nxt;
  set_t              set_r, set_nxt;
  set_t              eps_r [NUM_STATES];
  state_idx_t        st_r, st_nxt;
  sym_t              sym_r, sym_nxt;
  logic              rd_vld_r;
  state_idx_t        rd_st_r;
  logic [NUM_STATES-1:0] mem_rd_r;
  set_t              mem [1 << ADDR_W];

  logic              out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0] out_mask_r;
  logic              out_acc_r;
  logic              out_load;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  set_t              wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic              eps_we;
  set_t              eps_grow;
  set_t              scan_add;
  set_t              start_set;

  assign live      = state_r != ST_CLEAR;
  assign rd_addr   = {st_r, sym_r};
  assign scan_add  = (rd_vld_r && active_r[rd_st_r]) ? mem_rd_r : '0;
  assign start_set = (int'(start_state) < NUM_STATES) ?
                     (set_t'(1) << STATE_W'(start_state)) : '0;

  always_comb begin
    eps_grow = set_r;
    for (int i = 0; i < NUM_STATES; i++) begin
      if (set_r[i]) begin
        eps_grow = eps_grow | eps_r[i];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    active_nxt    = active_r;
    set_nxt       = set_r;
    st_nxt        = st_r;
    sym_nxt       = sym_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = {q_head.from, q_head.sym};
    wr_data       = q_head.mask;
    eps_we        = 1'b0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_if.ready;
    case (state_r)
      ST_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        wr_data      = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          sym_nxt = q_head.sym;
          case (q_head.op)
            OP_WR_TAB: begin
              wr_en     = 1'b1;
              state_nxt = ST_DONE;
            end
            OP_WR_EPS: begin
              eps_we    = 1'b1;
              state_nxt = ST_DONE;
            end
            OP_BEGIN: begin
              set_nxt   = start_set;
              state_nxt = ST_CLOSE;
            end
            OP_FEED: begin
              set_nxt   = '0;
              st_nxt    = '0;
              state_nxt = ST_SCAN;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        set_nxt = set_r | scan_add;
        st_nxt  = st_r + 1'b1;
        if (st_r == STATE_W'(NUM_STATES - 1)) begin
          state_nxt = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        set_nxt   = set_r | scan_add;
        state_nxt = ST_CLOSE;
      end
      ST_CLOSE: begin
        set_nxt = eps_grow;
        if (eps_grow == set_r) begin
          active_nxt = set_r;
          state_nxt  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      active_r    <= '0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      for (int i = 0; i < NUM_STATES; i++) begin
        eps_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= state_r == ST_SCAN;
      if (eps_we) begin
        eps_r[q_head.from] <= q_head.mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    set_r   <= set_nxt;
    st_r    <= st_nxt;
    sym_r   <= sym_nxt;
    rd_st_r <= st_r;
    if (out_load) begin
      out_mask_r <= set_to_mask(active_r);
      out_acc_r  <= (set_to_mask(active_r) & accept_mask) != '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_rd_r <= mem[rd_addr];
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.active_mask = out_mask_r;
  assign out_if.accepted    = out_acc_r;

endmodule
